@@ hw/rtl/pead_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pead_pkg
// Control word layout and program step addresses shared by the control
// store and the sequencer of the prime and even sum accumulator.
// ----------------------------------------------------------------------------
package pead_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DIV_W  = 16;   // trial divisor never exceeds 46341
   localparam int unsigned UPC_W  = 4;

   typedef logic [UPC_W-1:0] upc_type;

   // Datapath operation performed while a step is active
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,     // take a request into the operand registers
      OP_INIT,     // divisor = 2, square = 4, prime flag = 0
      OP_MARK,     // prime flag = square exceeds candidate
      OP_DIV_GO,   // launch remainder unit
      OP_STEP,     // advance divisor and its square
      OP_ACCUM,    // fold the value into the sums
      OP_EMIT      // load result register, clear the sums
   } op_type;

   // Jump condition: taken goes to target, otherwise fall through
   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_NOT_CAND,
      CND_SQ_GT,
      CND_DIV_BUSY,
      CND_REM_ZERO,
      CND_NOT_LAST
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ctrl_type;

   // Program step addresses
   localparam upc_type STEP_LOAD   = 4'd0;
   localparam upc_type STEP_INIT   = 4'd1;
   localparam upc_type STEP_MARK   = 4'd2;
   localparam upc_type STEP_DIV_GO = 4'd3;
   localparam upc_type STEP_WAIT   = 4'd4;
   localparam upc_type STEP_REM    = 4'd5;
   localparam upc_type STEP_NEXT   = 4'd6;
   localparam upc_type STEP_ACCUM  = 4'd7;
   localparam upc_type STEP_EMIT   = 4'd8;
   localparam upc_type STEP_RETURN = 4'd9;

endpackage

@@ hw/rtl/prime_and_even_sum_accumulator_core.sv @@
`timescale 1ns / 1ps
// A value that is negative, zero or one skips trial division; two or three is found prime
// at the first square check; otherwise each trial divisor waits on the remainder unit.
// A new request is taken only at the load step, once the previous value is processed.
// A last request also emits the result, waiting while the result register is occupied.
// Reset (synchronous, active high) clears both sums and returns to step zero.
// ----------------------------------------------------------------------------
// prime_and_even_sum_accumulator_core
// Microcoded sequencer with trial-division datapath; sums primes and even
// values of each set and reports both sums and the larger on the last request.
// ----------------------------------------------------------------------------
module prime_and_even_sum_accumulator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_value,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_prime_total,
   output logic signed [31:0]  rsp_even_total,
   output logic signed [31:0]  rsp_max_sum
);

   localparam int unsigned DW = pead_pkg::DATA_W;
   localparam int unsigned VW = pead_pkg::DIV_W;

   pead_pkg::upc_type   upc_ff;
   pead_pkg::upc_type   upc_in;
   pead_pkg::ctrl_type  ctrl;

   logic [DW-1:0]  value_ff;
   logic           last_ff;
   logic [VW-1:0]  d_ff;
   logic [DW-1:0]  sq_ff;
   logic           prime_ff;
   logic [DW-1:0]  prime_acc_ff;
   logic [DW-1:0]  even_acc_ff;
   logic           rsp_valid_ff;
   logic [DW-1:0]  rsp_prime_ff;
   logic [DW-1:0]  rsp_even_ff;
   logic [DW-1:0]  rsp_max_ff;

   logic           div_start;
   logic           div_busy;
   logic [VW-1:0]  div_rem;

   logic           not_cand;
   logic           sq_gt;
   logic           rsp_busy;
   logic           emit_go;
   logic           cond_hit;
   logic [DW-1:0]  prime_next;
   logic [DW-1:0]  even_next;

   pead_rom u_rom (
      .upc  (upc_ff),
      .ctrl (ctrl)
   );

   pead_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign not_cand  = value_ff[DW-1] || (value_ff[DW-2:1] == '0);
   assign sq_gt     = sq_ff > value_ff;
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign emit_go   = (ctrl.op == pead_pkg::OP_EMIT) && !rsp_busy;
   assign div_start = (ctrl.op == pead_pkg::OP_DIV_GO);
   assign req_ready = (ctrl.op == pead_pkg::OP_LOAD);

   assign prime_next = prime_ff ? (prime_acc_ff + value_ff) : prime_acc_ff;
   assign even_next  = !value_ff[0] ? (even_acc_ff + value_ff) : even_acc_ff;

   always_comb begin
      unique case (ctrl.cond)
         pead_pkg::CND_NEVER:    cond_hit = 1'b0;
         pead_pkg::CND_ALWAYS:   cond_hit = 1'b1;
         pead_pkg::CND_NO_REQ:   cond_hit = !req_valid;
         pead_pkg::CND_NOT_CAND: cond_hit = not_cand;
         pead_pkg::CND_SQ_GT:    cond_hit = sq_gt;
         pead_pkg::CND_DIV_BUSY: cond_hit = div_busy;
         pead_pkg::CND_REM_ZERO: cond_hit = (div_rem == '0);
         pead_pkg::CND_NOT_LAST: cond_hit = !last_ff;
         default:                cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      priority if (cond_hit) begin
         upc_in = ctrl.target;
      end else if ((ctrl.op == pead_pkg::OP_EMIT) && rsp_busy) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= pead_pkg::STEP_LOAD;
         prime_acc_ff <= '0;
         even_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;

         if (rsp_valid_ff && rsp_ready && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (ctrl.op)
            pead_pkg::OP_LOAD: begin
               if (req_valid) begin
                  value_ff <= req_value;
                  last_ff  <= req_last;
               end
            end
            pead_pkg::OP_INIT: begin
               d_ff     <= VW'(2);
               sq_ff    <= DW'(4);
               prime_ff <= 1'b0;
            end
            pead_pkg::OP_MARK: begin
               prime_ff <= sq_gt;
            end
            pead_pkg::OP_STEP: begin
               // (d+1)^2 = d^2 + 2d + 1
               sq_ff <= sq_ff + {{(DW-VW-1){1'b0}}, d_ff, 1'b1};
               d_ff  <= d_ff + 1'b1;
            end
            pead_pkg::OP_ACCUM: begin
               prime_acc_ff <= prime_next;
               even_acc_ff  <= even_next;
            end
            pead_pkg::OP_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= prime_acc_ff;
                  rsp_even_ff  <= even_acc_ff;
                  rsp_max_ff   <= ($signed(prime_acc_ff) > $signed(even_acc_ff)) ?
                                  prime_acc_ff : even_acc_ff;
                  prime_acc_ff <= '0;
                  even_acc_ff  <= '0;
               end
            end
            pead_pkg::OP_NONE,
            pead_pkg::OP_DIV_GO: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_total = rsp_prime_ff;
   assign rsp_even_total  = rsp_even_ff;
   assign rsp_max_sum     = rsp_max_ff;

endmodule

@@ hw/rtl/pead_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pead_rom
// Control store: one control word per program step of the primality test
// and accumulation sequence.
// ----------------------------------------------------------------------------
module pead_rom (
   input  pead_pkg::upc_type  upc,
   output pead_pkg::ctrl_type ctrl
);

   always_comb begin
      unique case (upc)
         pead_pkg::STEP_LOAD: begin
            ctrl = '{pead_pkg::OP_LOAD, pead_pkg::CND_NO_REQ, pead_pkg::STEP_LOAD};
         end
         pead_pkg::STEP_INIT: begin
            ctrl = '{pead_pkg::OP_INIT, pead_pkg::CND_NOT_CAND, pead_pkg::STEP_ACCUM};
         end
         pead_pkg::STEP_MARK: begin
            ctrl = '{pead_pkg::OP_MARK, pead_pkg::CND_SQ_GT, pead_pkg::STEP_ACCUM};
         end
         pead_pkg::STEP_DIV_GO: begin
            ctrl = '{pead_pkg::OP_DIV_GO, pead_pkg::CND_NEVER, pead_pkg::STEP_LOAD};
         end
         pead_pkg::STEP_WAIT: begin
            ctrl = '{pead_pkg::OP_NONE, pead_pkg::CND_DIV_BUSY, pead_pkg::STEP_WAIT};
         end
         pead_pkg::STEP_REM: begin
            ctrl = '{pead_pkg::OP_NONE, pead_pkg::CND_REM_ZERO, pead_pkg::STEP_ACCUM};
         end
         pead_pkg::STEP_NEXT: begin
            ctrl = '{pead_pkg::OP_STEP, pead_pkg::CND_ALWAYS, pead_pkg::STEP_MARK};
         end
         pead_pkg::STEP_ACCUM: begin
            ctrl = '{pead_pkg::OP_ACCUM, pead_pkg::CND_NOT_LAST, pead_pkg::STEP_LOAD};
         end
         pead_pkg::STEP_EMIT: begin
            // hold here while the result register is still occupied
            ctrl = '{pead_pkg::OP_EMIT, pead_pkg::CND_NEVER, pead_pkg::STEP_LOAD};
         end
         pead_pkg::STEP_RETURN: begin
            ctrl = '{pead_pkg::OP_NONE, pead_pkg::CND_ALWAYS, pead_pkg::STEP_LOAD};
         end
         default: begin
            ctrl = '{pead_pkg::OP_NONE, pead_pkg::CND_ALWAYS, pead_pkg::STEP_LOAD};
         end
      endcase
   end

endmodule

@@ hw/rtl/pead_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pead_div
// Restoring remainder unit: one quotient bit per cycle, one for each
// dividend bit. Busy is high from the cycle after start until done.
// ----------------------------------------------------------------------------
module pead_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pead_pkg::DATA_W-1:0]   dividend,
   input  logic [pead_pkg::DIV_W-1:0]    divisor,
   output logic                          busy,
   output logic [pead_pkg::DIV_W-1:0]    remainder
);

   localparam int unsigned CNT_W = $clog2(pead_pkg::DATA_W);

   logic                          busy_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [pead_pkg::DATA_W-1:0]   quo_ff;
   logic [pead_pkg::DIV_W:0]      rem_ff;
   logic [pead_pkg::DIV_W-1:0]    div_ff;
   logic [pead_pkg::DIV_W:0]      trial;
   logic [pead_pkg::DIV_W:0]      rem_in;

   assign trial  = {rem_ff[pead_pkg::DIV_W-1:0], quo_ff[pead_pkg::DATA_W-1]};
   assign rem_in = (trial >= {1'b0, div_ff}) ? (trial - {1'b0, div_ff}) : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         div_ff  <= divisor;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[pead_pkg::DATA_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(pead_pkg::DATA_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[pead_pkg::DIV_W-1:0];

endmodule
